/* rtl/core/sst_pkg.sv */
package sst_pkg;

    localparam int LINE_BITS = 32;
    localparam int NUM_W = 63;
    localparam logic [NUM_W-1:0] NUM_MAX = {NUM_W{1'b1}};

    typedef enum logic [3:0] {
        M_BETWEEN, M_HASH, M_SLASH, M_BCOMM, M_BSTAR, M_QUOTE, M_QESC,
        M_TAGSTART, M_TAG, M_NUMBER, M_IDENT, M_INTRO, M_INTROHASH, M_BODY,
        M_HALT
    } mode_t;

    localparam logic [2:0] K_CONTENT = 3'd0;
    localparam logic [2:0] K_TOKEN   = 3'd1;
    localparam logic [2:0] K_DISCARD = 3'd2;
    localparam logic [2:0] K_ERROR   = 3'd3;
    localparam logic [2:0] K_END     = 3'd4;

    localparam logic [3:0] T_QUOTED = 4'd8;
    localparam logic [3:0] T_MULTI  = 4'd9;
    localparam logic [3:0] T_NUMBER = 4'd10;
    localparam logic [3:0] T_IDENT  = 4'd11;
    localparam logic [3:0] T_TAG    = 4'd12;
    localparam logic [3:0] T_END    = 4'd13;

    localparam logic [2:0] E_COMMENT = 3'd0;
    localparam logic [2:0] E_QUOTE   = 3'd1;
    localparam logic [2:0] E_JUNK    = 3'd2;
    localparam logic [2:0] E_MULTI   = 3'd3;
    localparam logic [2:0] E_NOTAG   = 3'd4;
    localparam logic [2:0] E_CHAR    = 3'd5;

    typedef struct packed {
        logic [2:0]       kind;
        logic [3:0]       token_type;
        logic [15:0]      char_out;
        logic [NUM_W-1:0] number_value;
        logic [31:0]      line_number;
        logic [2:0]       error_code;
        logic             last;
    } result_t;

    typedef struct packed {
        logic       op;
        logic [15:0] ch;
    } item_t;

endpackage

/* rtl/core/sst_if.sv */
interface sst_in_if;
    import sst_pkg::*;
    logic  valid;
    logic  ready;
    item_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface sst_out_if;
    import sst_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/sst_lexer.sv */
module sst_lexer
    import sst_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  item_t            item,
    output logic [1:0]       count,
    output result_t          res0,
    output result_t          res1
);

    mode_t                  mode_reg, mode_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [31:0]            start_reg, start_next;
    logic [NUM_W-1:0]       acc_reg, acc_next;
    logic [2:0]             twm_reg, twm_next;
    logic [1:0]             tls_reg, tls_next;

    logic [15:0] c;
    logic [15:0] low;
    logic [31:0] line32;
    logic        is_digit, is_start, is_ichar, is_punct;
    logic [2:0]  punct_idx;
    logic [3:0]  digit;
    logic [NUM_W-1:0] acc_mul, scaled;
    logic [NUM_W+3:0] acc_x10;
    logic [7:0]  tw_char;
    result_t     r [2];
    logic [1:0]  n;
    logic        do_between;
    logic [31:0] bstart;

    assign c = item.ch;
    assign low = c | 16'h0020;
    assign line32 = 32'(line_reg);
    assign is_digit = (c >= 16'd48) && (c <= 16'd57);
    assign is_start = ((c >= 16'd97) && (c <= 16'd122)) ||
                      ((c >= 16'd65) && (c <= 16'd90)) || (c == 16'd95);
    assign is_ichar = is_start || is_digit;
    assign digit = c[3:0];
    // acc * 10 + digit, saturating at NUM_MAX
    assign acc_x10 = (NUM_W+4)'({acc_reg, 3'b000}) + (NUM_W+4)'({acc_reg, 1'b0})
                   + (NUM_W+4)'(digit);
    assign acc_mul = (acc_x10 > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : acc_x10[NUM_W-1:0];

    always_comb
    begin
        is_punct = 1'b1;
        punct_idx = 3'd0;
        case (c)
            16'h007B: punct_idx = 3'd0;
            16'h007D: punct_idx = 3'd1;
            16'h005B: punct_idx = 3'd2;
            16'h005D: punct_idx = 3'd3;
            16'h0028: punct_idx = 3'd4;
            16'h0029: punct_idx = 3'd5;
            16'h002C: punct_idx = 3'd6;
            16'h003B: punct_idx = 3'd7;
            default:  is_punct = 1'b0;
        endcase
    end

    always_comb
    begin
        case (twm_reg[1:0])
            2'd0:    tw_char = 8'h74;
            2'd1:    tw_char = 8'h65;
            2'd2:    tw_char = 8'h78;
            default: tw_char = 8'h74;
        endcase
    end

    always_comb
    begin
        case (low)
            16'h006B: scaled = (acc_reg > (NUM_MAX >> 10)) ? NUM_MAX : acc_reg << 10;
            16'h006D: scaled = (acc_reg > (NUM_MAX >> 20)) ? NUM_MAX : acc_reg << 20;
            default:  scaled = (acc_reg > (NUM_MAX >> 30)) ? NUM_MAX : acc_reg << 30;
        endcase
    end

    function automatic result_t mk(logic [2:0] k, logic [3:0] t, logic [15:0] ch,
                                   logic [NUM_W-1:0] num, logic [31:0] ln,
                                   logic [2:0] e);
        result_t x;
        x.kind = k;
        x.token_type = t;
        x.char_out = ch;
        x.number_value = num;
        x.line_number = ln;
        x.error_code = e;
        x.last = 1'b0;
        return x;
    endfunction

    always_comb
    begin
        mode_next = mode_reg;
        line_next = line_reg;
        start_next = start_reg;
        acc_next = acc_reg;
        twm_next = twm_reg;
        tls_next = tls_reg;
        r[0] = '0;
        r[1] = '0;
        n = 2'd0;
        do_between = 1'b0;
        bstart = start_reg;

        if (item.op)
        begin
            case (mode_reg)
                M_SLASH:
                begin
                    r[0] = mk(K_ERROR, 4'd0, 16'h002F, '0, start_reg, E_CHAR);
                    n = 2'd1;
                end
                M_BCOMM, M_BSTAR:
                begin
                    r[0] = mk(K_ERROR, 4'd0, '0, '0, start_reg, E_COMMENT);
                    n = 2'd1;
                end
                M_QUOTE, M_QESC:
                begin
                    r[0] = mk(K_ERROR, 4'd0, '0, '0, start_reg, E_QUOTE);
                    n = 2'd1;
                end
                M_TAGSTART:
                begin
                    r[0] = mk(K_ERROR, 4'd0, '0, '0, start_reg, E_NOTAG);
                    n = 2'd1;
                end
                M_TAG:
                begin
                    r[0] = mk(K_TOKEN, T_TAG, '0, '0, start_reg, 3'd0);
                    n = 2'd1;
                end
                M_NUMBER:
                begin
                    r[0] = mk(K_TOKEN, T_NUMBER, '0, acc_reg, start_reg, 3'd0);
                    n = 2'd1;
                end
                M_IDENT:
                begin
                    r[0] = mk(K_TOKEN, T_IDENT, '0, '0, start_reg, 3'd0);
                    n = 2'd1;
                end
                M_INTRO, M_INTROHASH:
                begin
                    r[0] = mk(K_ERROR, 4'd0, '0, '0, start_reg, E_MULTI);
                    n = 2'd1;
                end
                M_BODY:
                begin
                    if (tls_reg == 2'd1)
                        r[0] = mk(K_TOKEN, T_MULTI, '0, '0, start_reg, 3'd0);
                    else
                        r[0] = mk(K_ERROR, 4'd0, '0, '0, start_reg, E_MULTI);
                    n = 2'd1;
                end
                default: ;
            endcase
            r[n[0]] = mk(K_END, T_END, '0, '0, line32, 3'd0);
            n = n + 2'd1;
            mode_next = M_BETWEEN;
            line_next = LINE_BITS'(1);
            start_next = '0;
            acc_next = '0;
            twm_next = '0;
            tls_next = '0;
        end
        else if (mode_reg != M_HALT)
        begin
            case (mode_reg)
                M_BETWEEN: do_between = 1'b1;
                M_HASH: if (c == 16'h000A) mode_next = M_BETWEEN;
                M_SLASH:
                begin
                    if (c == 16'h002A)
                        mode_next = M_BCOMM;
                    else
                    begin
                        r[0] = mk(K_ERROR, 4'd0, 16'h002F, '0, start_reg, E_CHAR);
                        n = 2'd1;
                        mode_next = M_HALT;
                    end
                end
                M_BCOMM: if (c == 16'h002A) mode_next = M_BSTAR;
                M_BSTAR:
                begin
                    if (c == 16'h002F)
                        mode_next = M_BETWEEN;
                    else if (c != 16'h002A)
                        mode_next = M_BCOMM;
                end
                M_QUOTE:
                begin
                    n = 2'd1;
                    if (c == 16'h005C)
                    begin
                        mode_next = M_QESC;
                        n = 2'd0;
                    end
                    else if (c == 16'h0022)
                    begin
                        r[0] = mk(K_TOKEN, T_QUOTED, '0, '0, start_reg, 3'd0);
                        mode_next = M_BETWEEN;
                    end
                    else
                        r[0] = mk(K_CONTENT, T_QUOTED, c, '0, start_reg, 3'd0);
                end
                M_QESC:
                begin
                    r[0] = mk(K_CONTENT, T_QUOTED, c, '0, start_reg, 3'd0);
                    n = 2'd1;
                    mode_next = M_QUOTE;
                end
                M_TAGSTART:
                begin
                    n = 2'd1;
                    if (is_start)
                    begin
                        r[0] = mk(K_CONTENT, T_TAG, c, '0, start_reg, 3'd0);
                        mode_next = M_TAG;
                    end
                    else
                    begin
                        r[0] = mk(K_ERROR, 4'd0, '0, '0, start_reg, E_NOTAG);
                        mode_next = M_HALT;
                    end
                end
                M_TAG:
                begin
                    n = 2'd1;
                    if (is_ichar)
                        r[0] = mk(K_CONTENT, T_TAG, c, '0, start_reg, 3'd0);
                    else
                    begin
                        r[0] = mk(K_TOKEN, T_TAG, '0, '0, start_reg, 3'd0);
                        mode_next = M_BETWEEN;
                        do_between = 1'b1;
                    end
                end
                M_NUMBER:
                begin
                    n = 2'd1;
                    if (is_digit)
                    begin
                        acc_next = acc_mul;
                        r[0] = mk(K_CONTENT, T_NUMBER, c, '0, start_reg, 3'd0);
                    end
                    else if (low == 16'h006B || low == 16'h006D || low == 16'h0067)
                    begin
                        r[0] = mk(K_TOKEN, T_NUMBER, '0, scaled, start_reg, 3'd0);
                        mode_next = M_BETWEEN;
                    end
                    else
                    begin
                        r[0] = mk(K_TOKEN, T_NUMBER, '0, acc_reg, start_reg, 3'd0);
                        mode_next = M_BETWEEN;
                        do_between = 1'b1;
                    end
                end
                M_IDENT:
                begin
                    n = 2'd1;
                    if (is_ichar)
                    begin
                        if (twm_reg < 3'd4 && low == {8'd0, tw_char})
                            twm_next = twm_reg + 3'd1;
                        else
                            twm_next = 3'd7;
                        r[0] = mk(K_CONTENT, T_IDENT, c, '0, start_reg, 3'd0);
                    end
                    else if (c == 16'h003A && twm_reg == 3'd4)
                    begin
                        r[0] = mk(K_DISCARD, T_IDENT, '0, '0, start_reg, 3'd0);
                        mode_next = M_INTRO;
                    end
                    else
                    begin
                        r[0] = mk(K_TOKEN, T_IDENT, '0, '0, start_reg, 3'd0);
                        mode_next = M_BETWEEN;
                        do_between = 1'b1;
                    end
                end
                M_INTRO:
                begin
                    if (c == 16'h000A)
                    begin
                        mode_next = M_BODY;
                        tls_next = 2'd0;
                    end
                    else if (c == 16'h0023)
                        mode_next = M_INTROHASH;
                    else if (c != 16'h0020 && c != 16'h0009 && c != 16'h000D)
                    begin
                        r[0] = mk(K_ERROR, 4'd0, '0, '0, line32, E_JUNK);
                        n = 2'd1;
                        mode_next = M_HALT;
                    end
                end
                M_INTROHASH:
                begin
                    if (c == 16'h000A)
                    begin
                        mode_next = M_BODY;
                        tls_next = 2'd0;
                    end
                end
                M_BODY:
                begin
                    if (c == 16'h000A)
                    begin
                        if (tls_reg == 2'd1)
                        begin
                            r[0] = mk(K_TOKEN, T_MULTI, '0, '0, start_reg, 3'd0);
                            n = 2'd1;
                            mode_next = M_BETWEEN;
                        end
                        else
                        begin
                            r[0] = mk(K_CONTENT, T_MULTI, 16'h000D, '0, start_reg, 3'd0);
                            r[1] = mk(K_CONTENT, T_MULTI, 16'h000A, '0, start_reg, 3'd0);
                            n = 2'd2;
                        end
                        tls_next = 2'd0;
                    end
                    else if (c == 16'h002E && tls_reg == 2'd0)
                        tls_next = 2'd1;
                    else if (c != 16'h000D)
                    begin
                        r[0] = mk(K_CONTENT, T_MULTI, c, '0, start_reg, 3'd0);
                        n = 2'd1;
                        tls_next = 2'd2;
                    end
                end
                default: ;
            endcase

            if (do_between && !(c == 16'h0020 || c == 16'h0009 ||
                                c == 16'h000D || c == 16'h000A))
            begin
                bstart = line32;
                start_next = line32;
                if (is_punct)
                begin
                    r[n[0]] = mk(K_TOKEN, {1'b0, punct_idx}, '0, '0, bstart, 3'd0);
                    n = n + 2'd1;
                end
                else if (c == 16'h0023)
                    mode_next = M_HASH;
                else if (c == 16'h002F)
                    mode_next = M_SLASH;
                else if (c == 16'h0022)
                    mode_next = M_QUOTE;
                else if (c == 16'h003A)
                    mode_next = M_TAGSTART;
                else if (is_digit)
                begin
                    acc_next = NUM_W'(digit);
                    mode_next = M_NUMBER;
                    r[n[0]] = mk(K_CONTENT, T_NUMBER, c, '0, bstart, 3'd0);
                    n = n + 2'd1;
                end
                else if (is_start)
                begin
                    twm_next = (low == 16'h0074) ? 3'd1 : 3'd7;
                    mode_next = M_IDENT;
                    r[n[0]] = mk(K_CONTENT, T_IDENT, c, '0, bstart, 3'd0);
                    n = n + 2'd1;
                end
                else
                begin
                    r[n[0]] = mk(K_ERROR, 4'd0, c, '0, line32, E_CHAR);
                    n = n + 2'd1;
                    mode_next = M_HALT;
                end
            end

            if (c == 16'h000A && mode_next != M_HALT)
                line_next = line_reg + LINE_BITS'(1);
        end

        if (n == 2'd2)
            r[1].last = 1'b1;
        else
            r[0].last = 1'b1;
    end

    assign count = n;
    assign res0 = r[0];
    assign res1 = r[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= M_BETWEEN;
            line_reg <= LINE_BITS'(1);
            start_reg <= '0;
            acc_reg <= '0;
            twm_reg <= '0;
            tls_reg <= '0;
        end
        else if (step)
        begin
            mode_reg <= mode_next;
            line_reg <= line_next;
            start_reg <= start_next;
            acc_reg <= acc_next;
            twm_reg <= twm_next;
            tls_reg <= tls_next;
        end
    end

endmodule

/* rtl/core/sieve_script_tokenizer_top.sv */
// Sieve script lexer. Takes one character (op 0) or end-of-script (op 1) per
// transfer and gives zero, one or two results per item, the last flagged by
// last. The lexer state updates in the cycle an item is taken; results wait in
// a four-entry output queue. An item is taken in any cycle in which the queue
// can hold two more results, so one item per cycle is sustained while the
// output side keeps up. After an error, characters give nothing until the end
// item, which always yields End and returns the lexer to its reset state.
module sieve_script_tokenizer_top
    import sst_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sst_in_if.sink    in_ch,
    sst_out_if.source out_ch
);

    result_t    q_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] cnt_reg;
    logic [1:0] n;
    result_t    res0, res1;
    logic       step, pop;

    assign in_ch.ready = (cnt_reg <= 3'd2);
    assign step = in_ch.valid && in_ch.ready;
    assign out_ch.valid = (cnt_reg != 3'd0);
    assign out_ch.data = q_reg[rd_reg];
    assign pop = out_ch.valid && out_ch.ready;

    sst_lexer u_lexer (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .item  (in_ch.data),
        .count (n),
        .res0  (res0),
        .res1  (res1)
    );

    always_ff @(posedge clk)
    begin
        if (step && n != 2'd0)
            q_reg[wr_reg] <= res0;
        if (step && n == 2'd2)
            q_reg[wr_reg + 2'd1] <= res1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg <= '0;
            wr_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (step)
                wr_reg <= wr_reg + n;
            if (pop)
                rd_reg <= rd_reg + 2'd1;
            cnt_reg <= cnt_reg + (step ? {1'b0, n} : 3'd0) - {2'b0, pop};
        end
    end

endmodule

/* tb/sieve_script_tokenizer_checker.sv */
`timescale 1ns / 100ps

module sieve_script_tokenizer_checker
    import sst_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    sst_in_if.sink  in_mon,
    sst_out_if.sink out_mon,
    output int     fail_count,
    output int     pending,
    output int     results_seen,
    output int     tokens_seen,
    output int     errors_seen
);

    mode_t       lx_mode;
    logic [31:0] lx_line;
    logic [31:0] lx_start;
    logic [62:0] lx_acc;
    logic [2:0]  lx_word;
    logic [1:0]  lx_lstat;

    result_t expected_q[$];
    result_t step_res[$];

    function automatic bit is_id_start(logic [15:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    endfunction

    function automatic bit is_id_char(logic [15:0] c);
        return is_id_start(c) || (c >= "0" && c <= "9");
    endfunction

    task automatic emit(logic [2:0] k, logic [3:0] t, logic [15:0] c,
                        logic [62:0] n, logic [31:0] ln, logic [2:0] e);
        result_t r;
        r.kind = k;
        r.token_type = t;
        r.char_out = c;
        r.number_value = n;
        r.line_number = ln;
        r.error_code = e;
        r.last = 1'b0;
        if (step_res.size() < 2)
            step_res.insert(step_res.size(), r);
    endtask

    task automatic raise_error(logic [2:0] e, logic [15:0] c, logic [31:0] ln);
        emit(K_ERROR, 4'd0, c, '0, ln, e);
        lx_mode = M_HALT;
    endtask

    task automatic lex_between(logic [15:0] c);
        logic [7:0] punct [8];
        punct = '{"{", "}", "[", "]", "(", ")", ",", ";"};
        if (c == " " || c == 16'd9 || c == 16'd13 || c == 16'd10)
            return;
        for (int i = 0; i < 8; i++)
            if (c == {8'd0, punct[i]})
            begin
                lx_start = lx_line;
                emit(K_TOKEN, 4'(i), '0, '0, lx_start, '0);
                return;
            end
        lx_start = lx_line;
        if (c == "#")
            lx_mode = M_HASH;
        else if (c == "/")
            lx_mode = M_SLASH;
        else if (c == "\"")
            lx_mode = M_QUOTE;
        else if (c == ":")
            lx_mode = M_TAGSTART;
        else if (c >= "0" && c <= "9")
        begin
            lx_acc = 63'(c - "0");
            lx_mode = M_NUMBER;
            emit(K_CONTENT, T_NUMBER, c, '0, lx_start, '0);
        end
        else if (is_id_start(c))
        begin
            lx_word = ((c | 16'h20) == "t") ? 3'd1 : 3'd7;
            lx_mode = M_IDENT;
            emit(K_CONTENT, T_IDENT, c, '0, lx_start, '0);
        end
        else
            raise_error(E_CHAR, c, lx_line);
    endtask

    task automatic lex_char(logic [15:0] c);
        logic [15:0] low;
        logic [63:0] d;
        logic [62:0] v;
        int          sh;
        logic [7:0]  word [4];
        word = '{"t", "e", "x", "t"};
        low = c | 16'h20;
        case (lx_mode)
            M_BETWEEN: lex_between(c);
            M_HASH: if (c == 16'd10) lx_mode = M_BETWEEN;
            M_SLASH:
                if (c == "*") lx_mode = M_BCOMM;
                else raise_error(E_CHAR, "/", lx_start);
            M_BCOMM: if (c == "*") lx_mode = M_BSTAR;
            M_BSTAR:
                if (c == "/") lx_mode = M_BETWEEN;
                else if (c != "*") lx_mode = M_BCOMM;
            M_QUOTE:
                if (c == "\\") lx_mode = M_QESC;
                else if (c == "\"")
                begin
                    emit(K_TOKEN, T_QUOTED, '0, '0, lx_start, '0);
                    lx_mode = M_BETWEEN;
                end
                else emit(K_CONTENT, T_QUOTED, c, '0, lx_start, '0);
            M_QESC:
            begin
                emit(K_CONTENT, T_QUOTED, c, '0, lx_start, '0);
                lx_mode = M_QUOTE;
            end
            M_TAGSTART:
                if (is_id_start(c))
                begin
                    emit(K_CONTENT, T_TAG, c, '0, lx_start, '0);
                    lx_mode = M_TAG;
                end
                else raise_error(E_NOTAG, '0, lx_start);
            M_TAG:
                if (is_id_char(c)) emit(K_CONTENT, T_TAG, c, '0, lx_start, '0);
                else
                begin
                    emit(K_TOKEN, T_TAG, '0, '0, lx_start, '0);
                    lx_mode = M_BETWEEN;
                    lex_between(c);
                end
            M_NUMBER:
                if (c >= "0" && c <= "9")
                begin
                    d = 64'(c - "0");
                    lx_acc = ({1'b0, lx_acc} > (({1'b0, NUM_MAX}) - d) / 10) ?
                        NUM_MAX : 63'({1'b0, lx_acc} * 10 + d);
                    emit(K_CONTENT, T_NUMBER, c, '0, lx_start, '0);
                end
                else if (low == "k" || low == "m" || low == "g")
                begin
                    sh = (low == "k") ? 10 : (low == "m") ? 20 : 30;
                    v = (lx_acc > (NUM_MAX >> sh)) ? NUM_MAX : (lx_acc << sh);
                    emit(K_TOKEN, T_NUMBER, '0, v, lx_start, '0);
                    lx_mode = M_BETWEEN;
                end
                else
                begin
                    emit(K_TOKEN, T_NUMBER, '0, lx_acc, lx_start, '0);
                    lx_mode = M_BETWEEN;
                    lex_between(c);
                end
            M_IDENT:
                if (is_id_char(c))
                begin
                    if (lx_word < 3'd4 && low == {8'd0, word[lx_word[1:0]]})
                        lx_word = lx_word + 3'd1;
                    else
                        lx_word = 3'd7;
                    emit(K_CONTENT, T_IDENT, c, '0, lx_start, '0);
                end
                else if (c == ":" && lx_word == 3'd4)
                begin
                    emit(K_DISCARD, T_IDENT, '0, '0, lx_start, '0);
                    lx_mode = M_INTRO;
                end
                else
                begin
                    emit(K_TOKEN, T_IDENT, '0, '0, lx_start, '0);
                    lx_mode = M_BETWEEN;
                    lex_between(c);
                end
            M_INTRO:
                if (c == 16'd10)
                begin
                    lx_mode = M_BODY;
                    lx_lstat = 2'd0;
                end
                else if (c == "#") lx_mode = M_INTROHASH;
                else if (c != " " && c != 16'd9 && c != 16'd13)
                    raise_error(E_JUNK, '0, lx_line);
            M_INTROHASH:
                if (c == 16'd10)
                begin
                    lx_mode = M_BODY;
                    lx_lstat = 2'd0;
                end
            M_BODY:
                if (c == 16'd13)
                    ;
                else if (c == 16'd10)
                begin
                    if (lx_lstat == 2'd1)
                    begin
                        emit(K_TOKEN, T_MULTI, '0, '0, lx_start, '0);
                        lx_mode = M_BETWEEN;
                    end
                    else
                    begin
                        emit(K_CONTENT, T_MULTI, 16'd13, '0, lx_start, '0);
                        emit(K_CONTENT, T_MULTI, 16'd10, '0, lx_start, '0);
                    end
                    lx_lstat = 2'd0;
                end
                else if (c == "." && lx_lstat == 2'd0)
                    lx_lstat = 2'd1;
                else
                begin
                    emit(K_CONTENT, T_MULTI, c, '0, lx_start, '0);
                    lx_lstat = 2'd2;
                end
            default: ;
        endcase
    endtask

    task automatic lex_reset();
        lx_mode = M_BETWEEN;
        lx_line = 32'd1;
        lx_start = '0;
        lx_acc = '0;
        lx_word = '0;
        lx_lstat = '0;
    endtask

    task automatic lex_end();
        case (lx_mode)
            M_SLASH: raise_error(E_CHAR, "/", lx_start);
            M_BCOMM, M_BSTAR: raise_error(E_COMMENT, '0, lx_start);
            M_QUOTE, M_QESC: raise_error(E_QUOTE, '0, lx_start);
            M_TAGSTART: raise_error(E_NOTAG, '0, lx_start);
            M_TAG: emit(K_TOKEN, T_TAG, '0, '0, lx_start, '0);
            M_NUMBER: emit(K_TOKEN, T_NUMBER, '0, lx_acc, lx_start, '0);
            M_IDENT: emit(K_TOKEN, T_IDENT, '0, '0, lx_start, '0);
            M_INTRO, M_INTROHASH: raise_error(E_MULTI, '0, lx_start);
            M_BODY:
                if (lx_lstat == 2'd1) emit(K_TOKEN, T_MULTI, '0, '0, lx_start, '0);
                else raise_error(E_MULTI, '0, lx_start);
            default: ;
        endcase
        emit(K_END, T_END, '0, '0, lx_line, '0);
    endtask

    task automatic predict_item(item_t it);
        step_res.delete();
        if (it.op)
        begin
            lex_end();
            lex_reset();
        end
        else if (lx_mode != M_HALT)
        begin
            lex_char(it.ch);
            if (it.ch == 16'd10 && lx_mode != M_HALT)
                lx_line = lx_line + 32'd1;
        end
        if (step_res.size() > 0)
            step_res[step_res.size() - 1].last = 1'b1;
        foreach (step_res[i])
            expected_q.insert(expected_q.size(), step_res[i]);
    endtask

    always @(posedge clk)
    begin
        result_t exp_r;
        if (!rst_n)
            lex_reset();
        else
        begin
            if (out_mon.valid && out_mon.ready)
            begin
                results_seen++;
                if (out_mon.data.kind == K_TOKEN) tokens_seen++;
                if (out_mon.data.kind == K_ERROR) errors_seen++;
                if (expected_q.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected result %p", out_mon.data);
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (exp_r !== out_mon.data)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p actual %p", exp_r, out_mon.data);
                    end
                end
            end
            if (in_mon.valid && in_mon.ready)
                predict_item(in_mon.data);
        end
        pending = expected_q.size();
    end

endmodule

/* tb/sieve_script_tokenizer_top_tb.sv */
`timescale 1ns / 100ps

module sieve_script_tokenizer_top_tb;
    import sst_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;
    int   results_seen;
    int   tokens_seen;
    int   errors_seen;
    int   idle_cycles;
    int   items_sent;
    bit   steady;

    sst_in_if  in_ch();
    sst_out_if out_ch();

    sieve_script_tokenizer_top u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    sieve_script_tokenizer_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_mon       (in_ch.sink),
        .out_mon      (out_ch.sink),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .tokens_seen  (tokens_seen),
        .errors_seen  (errors_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            out_ch.ready = steady || ($urandom_range(99) >= 34);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        @(posedge rst_n);
        wait (idle_cycles >= 2000);
        $display("status: fail");
        $finish;
    end

    task automatic send(logic op, logic [15:0] ch);
        while (!steady && $urandom_range(99) < 34)
        begin
            in_ch.valid = 1'b0;
            @(negedge clk);
        end
        in_ch.valid = 1'b1;
        in_ch.data.op = op;
        in_ch.data.ch = ch;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send(1'b0, {8'd0, s[i]});
    endtask

    function automatic logic [15:0] pick_char();
        string alpha;
        int r;
        alpha = "tTeExX aZ_09kKmMgG{}[](),;#/*\":\\.\n\r\t12345bq";
        r = $urandom_range(99);
        if (r < 85)
            return {8'd0, alpha[$urandom_range(alpha.len() - 1)]};
        else if (r < 92)
            return 16'($urandom);
        else
            return 16'(32 + $urandom_range(94));
    endfunction

    task automatic send_script();
        int n;
        int shape;
        shape = $urandom_range(9);
        if (shape < 3)
            send_text($sformatf("if size :over %0d%s {\n  fileinto \"a\\\"b\";\n}\n",
                      $urandom, shape == 0 ? "K" : shape == 1 ? "m" : "G"));
        else if (shape < 5)
        begin
            send_text(shape == 3 ? "Text: # c\r\n" : "text:\n");
            n = $urandom_range(6);
            for (int i = 0; i < n; i++)
                send(1'b0, $urandom_range(3) == 0 ? 16'h2E : pick_char());
            send_text("\r\n.");
            if ($urandom_range(1)) send_text("\n;");
        end
        else if (shape == 5)
            send_text("/* x ** y */ [\"p\", :tag2, 99999999999999999999999]");
        n = $urandom_range(30);
        for (int i = 0; i < n; i++)
            send(1'b0, pick_char());
        send(1'b1, 16'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        steady = 1'b0;
        items_sent = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_text("{}[](),;");
        send(1'b0, 16'hFFFF);
        send(1'b1, 16'h0000);
        send_text("9223372036854775808 7g :");
        send(1'b1, 16'hFFFF);
        send_text("/x");
        send(1'b1, 16'h0);

        while (items_sent < 2000)
        begin
            steady = (items_sent > 800 && items_sent < 1100);
            send_script();
            if ($urandom_range(15) == 0)
            begin
                in_ch.valid = 1'b0;
                wait (pending == 0);
                @(negedge clk);
            end
        end
        in_ch.valid = 1'b0;
        wait (pending == 0);
        repeat (20) @(posedge clk);
        $display("covered %0d items, %0d results, %0d tokens, %0d errors",
                 items_sent, results_seen, tokens_seen, errors_seen);
        if (fail_count == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
